>>> src/wpm_pkg.sv
// Shared types, constants and helper functions of the wildcard pattern matcher.
package wpm_pkg;

    // Largest mask the configuration registers can hold.
    localparam int MAX_LEN = 16;

    // Mask characters with a special meaning.
    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;

    // ASCII letter range that is folded when case is ignored.
    localparam logic [7:0] LOWER_A   = 8'h61;
    localparam logic [7:0] LOWER_Z   = 8'h7A;
    localparam logic [7:0] CASE_STEP = 8'h20;

    // Register indexes, one register every eight bytes.
    typedef enum logic [1:0] {
        REG_MASK_LOW,
        REG_MASK_HIGH,
        REG_MASK_LEN,
        REG_IGNORE_CASE
    } reg_index_t;

    // Decoded mask, refreshed from the configuration registers every cycle.
    typedef struct packed {
        logic                          ignore_case;
        logic [MAX_LEN-1:0]            star;
        logic [MAX_LEN-1:0]            any;
        logic [MAX_LEN-1:0]            in_use;
        logic [MAX_LEN:0]              len_onehot;
        logic [MAX_LEN-1:0][7:0]       fchar;
    } mask_info_t;

    // Fold a lower-case ASCII letter to upper case when requested.
    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic fold_en);
        logic [7:0] r;
        r = c;
        if (fold_en && (c >= LOWER_A) && (c <= LOWER_Z)) begin
            r = c - CASE_STEP;
        end
        return r;
    endfunction

endpackage

>>> src/wildcard_pattern_matcher_top.sv
// Top level of the wildcard pattern matcher: configuration port, word stages and live state.
//
// The block takes one word per cycle while char_stall is low. A word is held in an input register
// while the live-position vector is advanced by the star-closure and compare logic; the match
// flag of an end word lands in the result register at the edge that takes the word out of the
// input register, so it passes the input register and then the result register before the
// result port offers it. Character words keep flowing while a result waits; an end word waits
// in the input register only while the result register still holds an untaken result. Mask
// registers sit at byte addresses 0, 8, 16 and 24 on a 64-bit APB-style port and reach the
// matching logic through the registered mask decode.
module wildcard_pattern_matcher_top #(
    parameter int MASK_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Character channel
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  ch,
    input  logic        end_of_string,
    // Result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic        matched
);
    import wpm_pkg::*;

    logic [63:0]       mask_low_reg;
    logic [63:0]       mask_high_reg;
    logic [4:0]        mask_len_reg;
    logic              ignore_case_reg;
    reg_index_t        cfg_idx;
    logic              cfg_write;

    mask_info_t        info;

    logic              s1_valid_reg;
    logic [7:0]        s1_ch_reg;
    logic              s1_eos_reg;
    logic              s1_fire;
    logic              accept;

    logic [MASK_LEN:0] live_reg;
    logic [MASK_LEN:0] live_next;
    logic              match_next;
    logic              result_valid_reg;
    logic              matched_reg;

    assign pready    = 1'b1;
    assign cfg_idx   = reg_index_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mask_low_reg    <= '0;
            mask_high_reg   <= '0;
            mask_len_reg    <= '0;
            ignore_case_reg <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_MASK_LOW:    mask_low_reg    <= pwdata;
                REG_MASK_HIGH:   mask_high_reg   <= pwdata;
                REG_MASK_LEN:    mask_len_reg    <= pwdata[4:0];
                REG_IGNORE_CASE: ignore_case_reg <= pwdata[0];
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_idx)
            REG_MASK_LOW:    prdata = mask_low_reg;
            REG_MASK_HIGH:   prdata = mask_high_reg;
            REG_MASK_LEN:    prdata = {59'd0, mask_len_reg};
            REG_IGNORE_CASE: prdata = {63'd0, ignore_case_reg};
        endcase
    end

    wpm_mask_decode #(
        .MASK_LEN (MASK_LEN)
    ) u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .mask_chars_low  (mask_low_reg),
        .mask_chars_high (mask_high_reg),
        .mask_length     (mask_len_reg),
        .ignore_case     (ignore_case_reg),
        .info            (info)
    );

    // An end word leaves the input register only when the result register is free.
    assign s1_fire    = s1_valid_reg &&
                        (!s1_eos_reg || !result_valid_reg || !result_stall);
    assign char_stall = s1_valid_reg && !s1_fire;
    assign accept     = char_valid && !char_stall;

    wpm_step #(
        .MASK_LEN (MASK_LEN)
    ) u_step (
        .live          (live_reg),
        .ch            (s1_ch_reg),
        .end_of_string (s1_eos_reg),
        .info          (info),
        .live_next     (live_next),
        .matched       (match_next)
    );

    // Control state: input stage valid, live positions and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg     <= 1'b0;
            live_reg         <= (MASK_LEN+1)'(1);
            result_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                live_reg <= live_next;
            end
            if (s1_fire && s1_eos_reg) begin
                result_valid_reg <= 1'b1;
            end else if (!result_stall) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the input stage and the result stage.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_ch_reg  <= ch;
            s1_eos_reg <= end_of_string;
        end
        if (s1_fire && s1_eos_reg) begin
            matched_reg <= match_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign matched      = matched_reg;

endmodule

>>> src/wpm_mask_decode.sv
// Registered decode of the configured mask into per-position flags.
module wpm_mask_decode #(
    parameter int MASK_LEN = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [63:0]         mask_chars_low,
    input  logic [63:0]         mask_chars_high,
    input  logic [4:0]          mask_length,
    input  logic                ignore_case,
    output wpm_pkg::mask_info_t info
);
    import wpm_pkg::*;

    localparam logic [4:0] LEN_LIMIT = 5'(MASK_LEN);

    logic [127:0]       chars;
    logic [4:0]         lim;
    logic [MAX_LEN-1:0] nz;
    logic [MAX_LEN-1:0] below;
    mask_info_t         info_next;
    mask_info_t         info_reg;

    assign chars = {mask_chars_high, mask_chars_low};

    // A length above the supported mask size is taken as the mask size.
    assign lim = (mask_length > LEN_LIMIT) ? LEN_LIMIT : mask_length;

    // Per-position flags; the mask ends at the first zero byte.
    always_comb
    begin
        info_next = '0;
        info_next.ignore_case = ignore_case;
        for (int i = 0; i < MAX_LEN; i++) begin
            nz[i]    = (chars[8*i +: 8] != 8'h00);
            below[i] = (5'(i) < lim);
            info_next.star[i]  = (chars[8*i +: 8] == STAR_CHAR);
            info_next.any[i]   = (chars[8*i +: 8] == ANY_CHAR);
            info_next.fchar[i] = fold_char(chars[8*i +: 8], ignore_case);
        end
        for (int i = 0; i < MAX_LEN; i++) begin
            info_next.in_use[i] = below[i];
            for (int k = 0; k <= i; k++) begin
                info_next.in_use[i] = info_next.in_use[i] & nz[k];
            end
        end
        // Positions in use form a run from zero, so its end marks the length.
        info_next.len_onehot[0] = ~info_next.in_use[0];
        for (int j = 1; j < MAX_LEN; j++) begin
            info_next.len_onehot[j] = info_next.in_use[j-1] & ~info_next.in_use[j];
        end
        info_next.len_onehot[MAX_LEN] = info_next.in_use[MAX_LEN-1];
    end

    // Decode register; after reset the mask is empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            info_reg <= '{ignore_case: 1'b0,
                          star:        '0,
                          any:         '0,
                          in_use:      '0,
                          len_onehot:  (MAX_LEN+1)'(1),
                          fchar:       '0};
        end else begin
            info_reg <= info_next;
        end
    end

    assign info = info_reg;

endmodule

>>> src/wpm_step.sv
// Next live-position vector and match flag for one word.
module wpm_step #(
    parameter int MASK_LEN = 16
) (
    input  logic [MASK_LEN:0]   live,
    input  logic [7:0]          ch,
    input  logic                end_of_string,
    input  wpm_pkg::mask_info_t info,
    output logic [MASK_LEN:0]   live_next,
    output logic                matched
);
    import wpm_pkg::*;

    logic [MASK_LEN-1:0] star_eff;
    logic [MASK_LEN:0]   keep;
    logic [MASK_LEN:0]   len_hot;
    logic [MASK_LEN:0]   cur;
    logic [MASK_LEN:0]   adv;
    logic [7:0]          c;

    // Drop bits beyond the length, then spread each live bit across the
    // run of stars that follows it; each output bit is computed on its own.
    function automatic logic [MASK_LEN:0] close_run(
        input logic [MASK_LEN:0]   v,
        input logic [MASK_LEN-1:0] star,
        input logic [MASK_LEN:0]   msk
    );
        logic [MASK_LEN:0] kv;
        logic [MASK_LEN:0] r;
        logic              run;
        kv = v & msk;
        for (int j = 0; j <= MASK_LEN; j++) begin
            r[j] = kv[j];
            run  = 1'b1;
            for (int i = j - 1; i >= 0; i--) begin
                run  = run & star[i];
                r[j] = r[j] | (kv[i] & run);
            end
        end
        return r;
    endfunction

    assign len_hot  = info.len_onehot[MASK_LEN:0];
    assign star_eff = info.star[MASK_LEN-1:0] & info.in_use[MASK_LEN-1:0];
    assign keep     = {1'b0, info.in_use[MASK_LEN-1:0]} | len_hot;

    // Advance the automaton by one character, or report and restart on an end word.
    always_comb
    begin
        cur = close_run(live, star_eff, keep);
        c   = fold_char(ch, info.ignore_case);
        adv = '0;
        for (int i = 0; i < MASK_LEN; i++) begin
            if (cur[i] && info.in_use[i]) begin
                if (info.star[i]) begin
                    adv[i] = 1'b1;
                end else if (info.any[i] || (info.fchar[i] == c)) begin
                    adv[i+1] = 1'b1;
                end
            end
        end
        matched = |(cur & len_hot);
        if (end_of_string) begin
            live_next = (MASK_LEN+1)'(1);
        end else begin
            live_next = close_run(adv, star_eff, keep);
        end
    end

endmodule

>>> src/wpm_checker.sv
// Port-level checker of the wildcard pattern matcher and its bind to the top level.
module wpm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pready,
    input logic        char_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic        matched
);

    // The character side never waits while the result side can take a word.
    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!result_valid || !result_stall) |-> !char_stall)
        else $error("character stall while the result side is free");

    // A stalled result stays offered.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its match flag.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(matched))
        else $error("match flag changed while stalled");

    // The configuration port never inserts wait states.
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable) |-> pready)
        else $error("configuration access not ready");

endmodule

bind wildcard_pattern_matcher_top wpm_checker u_checker (.*);

>>> dv/tb_top.sv
// Testbench of the wildcard pattern matcher: APB mask setup, random strings and a match scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import wpm_pkg::*;

    typedef logic [7:0] text_q_t[$];

    // Tracks the live mask positions and holds the match bits still to come.
    class match_scoreboard;
        logic [63:0] mask_low;
        logic [63:0] mask_high;
        logic [4:0]  mask_len;
        logic        fold_en;
        int unsigned live;
        logic        expected_q[$];
        int          errors;

        function new();
            mask_low  = '0;
            mask_high = '0;
            mask_len  = '0;
            fold_en   = 1'b0;
            live      = 1;
            errors    = 0;
        endfunction

        // Mirror of a configuration register write.
        function void set_reg(reg_index_t idx, logic [63:0] value);
            case (idx)
                REG_MASK_LOW:    mask_low  = value;
                REG_MASK_HIGH:   mask_high = value;
                REG_MASK_LEN:    mask_len  = value[4:0];
                REG_IGNORE_CASE: fold_en   = value[0];
                default:         ;
            endcase
        endfunction

        function logic [7:0] mask_byte(int unsigned i);
            return (i < 8) ? mask_low[i*8 +: 8] : mask_high[(i-8)*8 +: 8];
        endfunction

        // Length in use: clipped to the mask size and cut at the first zero byte.
        function int unsigned used_len();
            int unsigned lim;
            lim = (mask_len > MAX_LEN) ? MAX_LEN : mask_len;
            for (int unsigned i = 0; i < lim; i++) begin
                if (mask_byte(i) == 8'h00) return i;
            end
            return lim;
        endfunction

        function logic [7:0] to_upper(logic [7:0] c);
            if (fold_en && c >= LOWER_A && c <= LOWER_Z) return c - CASE_STEP;
            return c;
        endfunction

        // Drop positions past the mask end, then let every live star also skip itself.
        function int unsigned widen(int unsigned v, int unsigned n);
            v &= (32'h1 << (n + 1)) - 1;
            for (int unsigned i = 0; i < n; i++) begin
                if (v[i] && mask_byte(i) == STAR_CHAR) v |= 32'h1 << (i + 1);
            end
            return v;
        endfunction

        // Advance the live positions by one accepted word.
        function void note_word(logic [7:0] c, logic eos);
            int unsigned n;
            int unsigned cur;
            int unsigned nxt;
            logic [7:0]  m;
            n   = used_len();
            cur = widen(live, n);
            if (eos) begin
                expected_q = {expected_q, cur[n]};
                live = 1;
                return;
            end
            nxt = 0;
            for (int unsigned i = 0; i < n; i++) begin
                if (cur[i]) begin
                    m = mask_byte(i);
                    if (m == STAR_CHAR) nxt |= 32'h1 << i;
                    else if (m == ANY_CHAR || to_upper(m) == to_upper(c))
                        nxt |= 32'h1 << (i + 1);
                end
            end
            live = widen(nxt, n) & 32'h1FFFF;
        endfunction

        // Compare a result word with the oldest expected match bit.
        function void check_result(logic got);
            logic want;
            if (expected_q.size() == 0) begin
                $error("matched: no result expected, actual %0d", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                $error("matched: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        char_valid = 1'b0;
    logic        char_stall;
    logic [7:0]  ch = '0;
    logic        end_of_string = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        matched;

    match_scoreboard sb = new();

    bit tx_busy;
    bit rx_busy;
    int hold_len;
    int item_count;

    logic [7:0] letters [8] = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h61, 8'h62, 8'h63, 8'h64};

    wildcard_pattern_matcher_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .ch            (ch),
        .end_of_string (end_of_string),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .matched       (matched)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: random stalls per word, plus a long hold-off on request.
    initial
    begin
        int pause;
        pause = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall) begin
                sb.check_result(matched);
                pause = rx_busy ? $urandom_range(0, 13) : 0;
            end
            if (hold_len > 0) begin
                pause    = hold_len;
                hold_len = 0;
            end
            if (pause > 0) begin
                result_stall <= 1'b1;
                pause--;
            end
            else begin
                result_stall <= 1'b0;
            end
        end
    end

    // One APB write: setup cycle, then access cycle.
    task automatic write_reg(reg_index_t idx, logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic wait_results();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // New mask setup, only once the block has gone quiet.
    task automatic configure(logic [63:0] low, logic [63:0] high, logic [4:0] len, logic fold);
        char_valid <= 1'b0;
        wait_results();
        repeat (4) @(posedge clk);
        write_reg(REG_MASK_LOW, low);
        write_reg(REG_MASK_HIGH, high);
        write_reg(REG_MASK_LEN, {59'd0, len});
        write_reg(REG_IGNORE_CASE, {63'd0, fold});
        repeat (2) @(posedge clk);
    endtask

    // Offer one word, after a random gap while tx_busy is set, and hold it until taken.
    task automatic send_word(logic [7:0] c, logic eos);
        int gap;
        gap = tx_busy ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid    <= 1'b1;
        ch            <= c;
        end_of_string <= eos;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        sb.note_word(c, eos);
        item_count++;
    endtask

    task automatic send_text(text_q_t s, bit with_end);
        foreach (s[i]) send_word(s[i], 1'b0);
        if (with_end) send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return letters[$urandom_range(0, 7)];
        if (r < 9) return 8'($urandom_range(1, 255));
        return 8'h00;
    endfunction

    function automatic logic [7:0] pick_mask_byte(bit allow_zero);
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)  return letters[$urandom_range(0, 7)];
        if (r < 12) return STAR_CHAR;
        if (r < 15) return ANY_CHAR;
        if (r < 19 || !allow_zero) return 8'($urandom_range(1, 255));
        return 8'h00;
    endfunction

    // Build a string that fits the current mask, then sometimes spoil it.
    function automatic text_q_t make_string();
        text_q_t     q;
        logic [7:0]  b;
        int unsigned n;
        int          pos;
        n = sb.used_len();
        for (int unsigned i = 0; i < n; i++) begin
            b = sb.mask_byte(i);
            if (b == STAR_CHAR) begin
                repeat ($urandom_range(0, 3)) q = {q, pick_char()};
            end
            else if (b == ANY_CHAR) begin
                q = {q, 8'($urandom_range(0, 255))};
            end
            else begin
                // Flip the case of letters when the block should ignore it.
                if (sb.fold_en && $urandom_range(0, 1) &&
                    ((b >= 8'h41 && b <= 8'h5A) || (b >= LOWER_A && b <= LOWER_Z)))
                    b = b ^ CASE_STEP;
                q = {q, b};
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            pos = (q.size() > 0) ? $urandom_range(0, q.size() - 1) : 0;
            case ($urandom_range(0, 2))
                0: if (q.size() > 0) q[pos] = pick_char();
                1: if (q.size() > 0) q.delete(pos);
                default: q.insert(pos, pick_char());
            endcase
        end
        return q;
    endfunction

    initial
    begin
        int          phase;
        int          start;
        int          drain;
        logic [63:0] low;
        logic [63:0] high;
        logic [4:0]  len;
        logic        fold;
        bit          zero_ok;
        text_q_t     text;

        tx_busy    = 1'b1;
        rx_busy    = 1'b1;
        hold_len   = 0;
        item_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Empty mask after reset: only the empty string matches.
        text.delete();
        send_text(text, 1'b1);
        send_text('{8'hFF}, 1'b1);

        // Mask "a*?B" with case folding, including a zero character.
        configure(64'h0000_0000_423F_2A61, 64'd0, 5'd4, 1'b1);
        send_text('{8'h41, 8'h7A, 8'h42}, 1'b1);
        send_text('{8'h61, 8'h00, 8'h78, 8'h62}, 1'b1);

        // Same mask, case sensitive now.
        configure(64'h0000_0000_423F_2A61, 64'd0, 5'd4, 1'b0);
        send_text('{8'h61, 8'h58, 8'h59, 8'h62}, 1'b1);

        // Mask replaced in the middle of a string.
        send_text('{8'h61}, 1'b0);
        configure(64'h0000_0000_0000_2A61, 64'd0, 5'd2, 1'b0);
        send_text('{8'h51}, 1'b1);

        // Random phases, each with its own mask and idling mix.
        for (phase = 0; phase < 12; phase++) begin
            zero_ok = (phase % 3 == 0);
            for (int i = 0; i < 8; i++) begin
                low[i*8 +: 8]  = pick_mask_byte(zero_ok);
                high[i*8 +: 8] = pick_mask_byte(zero_ok);
            end
            len  = 5'($urandom_range(0, 16));
            fold = 1'($urandom_range(0, 1));
            case (phase)
                0: begin low = '1; high = '1; len = 5'd31; fold = 1'b1; end
                1: begin low = '0; high = '0; len = 5'd16; end
                2: len = 5'd1;
                3: len = 5'd16;
                default: ;
            endcase
            tx_busy = !(phase == 5 || phase % 4 == 1);
            rx_busy = !(phase == 5 || phase % 4 == 2);
            configure(low, high, len, fold);

            // Hold the result side so end words pile up behind it.
            if (phase == 4) hold_len = 150;

            start = item_count;
            while (item_count - start < 48) begin
                if ($urandom_range(0, 6) == 0) begin
                    text.delete();
                    repeat ($urandom_range(0, 6)) text = {text, 8'($urandom_range(0, 255))};
                end
                else begin
                    text = make_string();
                end
                send_text(text, 1'b1);
                // In phases 6 and 9, the sender waits here until every result has come back.
                if ((phase == 6 || phase == 9) && item_count - start >= 24 &&
                    item_count - start < 40) begin
                    char_valid <= 1'b0;
                    wait_results();
                end
            end

            // Sometimes leave a string open across the mask change.
            if ($urandom_range(0, 2) == 0) begin
                text = make_string();
                send_text(text, 1'b0);
            end
        end

        // Close the last string so its live state is checked too.
        send_word(8'h00, 1'b1);
        char_valid <= 1'b0;

        drain = 0;
        while (sb.pending() != 0 && drain < 5000) begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        while (sb.pending() != 0) begin
            $error("matched: expected %0d, actual none", sb.expected_q.pop_front());
            sb.errors++;
        end

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
src/wpm_pkg.sv
src/wpm_mask_decode.sv
src/wpm_step.sv
src/wildcard_pattern_matcher_top.sv
src/wpm_checker.sv
dv/tb_top.sv
